/* hdl/u8esc_pkg.sv */
package u8esc_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 18;
   localparam int CAP_W  = 19;

   localparam logic [LEN_W-1:0] LEN_MAX   = '1;
   localparam logic [CAP_W-1:0] CAP_RESET = 19'h40000;

   // one queued unit of work: a byte copied as is, or a byte to be escaped
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_raw;
      logic              last;
      logic              eos;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* hdl/u8esc_req_if.sv */
interface u8esc_req_if;
   import u8esc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);

endinterface

/* hdl/u8esc_rsp_if.sv */
interface u8esc_rsp_if;
   import u8esc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              run_last;
   logic              string_done;
   logic              overflow;
   logic [LEN_W-1:0]  out_length;

   modport source (
      output valid, output out_byte, output run_last, output string_done,
      output overflow, output out_length, input ready
   );
   modport sink (
      input valid, input out_byte, input run_last, input string_done,
      input overflow, input out_length, output ready
   );

endinterface

/* hdl/u8esc_front.sv */
module u8esc_front (
   input  logic                      clock,
   input  logic                      reset,
   u8esc_req_if.sink                 req,
   input  u8esc_pkg::q_status_type   q_status,
   output logic                      push,
   output u8esc_pkg::op_type         push_op
);
   import u8esc_pkg::*;

   typedef enum logic [1:0] {
      ACT_SINGLE = 2'd0,
      ACT_COPY   = 2'd1,
      ACT_HOLD   = 2'd2
   } act_type;

   typedef struct packed {
      act_type    act;
      logic [1:0] need;
   } scan_type;

   function automatic logic [1:0] tail_need(input logic [BYTE_W-1:0] b);
      logic [1:0] k;
      k = 2'd0;
      if (b[7:5] == 3'b110) k = 2'd1;
      else if (b[7:4] == 4'b1110) k = 2'd2;
      else if (b[7:3] == 5'b11110) k = 2'd3;
      return k;
   endfunction

   // classify the byte at position i of the working window
   function automatic scan_type scan(input logic [3:0][BYTE_W-1:0] a, input logic [2:0] n,
                                     input logic [2:0] i, input logic e);
      logic [BYTE_W-1:0] b;
      logic [1:0]        k;
      logic [2:0]        avail;
      logic [2:0]        lim;
      logic [1:0]        idx;
      logic              ok;
      scan_type          r;
      b     = a[i[1:0]];
      k     = tail_need(b);
      avail = n - 3'd1 - i;
      lim   = (avail < {1'b0, k}) ? avail : {1'b0, k};
      ok    = 1'b1;
      for (int j = 1; j <= 3; j++) begin
         idx = i[1:0] + 2'(j);
         if (3'(j) <= lim && a[idx][7:6] != 2'b10) ok = 1'b0;
      end
      r.need = k;
      if (k == 2'd0) r.act = ACT_SINGLE;
      else if (!ok || (avail < {1'b0, k} && e)) r.act = ACT_SINGLE;
      else if (avail >= {1'b0, k}) r.act = ACT_COPY;
      else r.act = ACT_HOLD;
      return r;
   endfunction

   logic [3:0][BYTE_W-1:0] buf_ff, buf_in;
   logic [1:0]             held_ff, held_in;
   logic                   busy_ff, busy_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [2:0]             pos_ff, pos_in;
   logic                   eos_ff, eos_in;
   logic [1:0]             copy_ff, copy_in;

   logic [3:0][BYTE_W-1:0] arr;
   logic [2:0]             cnt, pos, nxt_pos, sp;
   logic                   eos, go, hold_now, last, fin;
   logic [1:0]             copy, copy_next;
   logic                   is_raw;
   scan_type               cur, nxt;

   assign req.ready = !busy_ff && !q_status.full;

   always_comb begin
      arr = buf_ff;
      if (!busy_ff) arr[held_ff] = req.in_byte;
      cnt  = busy_ff ? cnt_ff : {1'b0, held_ff} + 3'd1;
      pos  = busy_ff ? pos_ff : 3'd0;
      eos  = busy_ff ? eos_ff : req.end_of_string;
      copy = busy_ff ? copy_ff : 2'd0;
      go   = (busy_ff || (req.valid && req.ready)) && !q_status.full;

      cur      = scan(arr, cnt, pos, eos);
      nxt_pos  = pos + 3'd1;
      nxt      = scan(arr, cnt, nxt_pos, eos);
      hold_now = (copy == 2'd0) && (cur.act == ACT_HOLD);

      if (copy != 2'd0) begin
         is_raw    = 1'b1;
         copy_next = copy - 2'd1;
      end else if (cur.act == ACT_COPY) begin
         is_raw    = 1'b1;
         copy_next = cur.need;
      end else begin
         is_raw    = 1'b0;
         copy_next = 2'd0;
      end

      last = (copy_next == 2'd0) && (nxt_pos == cnt || nxt.act == ACT_HOLD);
      fin  = go && (hold_now || last);
      sp   = hold_now ? pos : nxt_pos;

      push           = go && !hold_now;
      push_op.data   = arr[pos[1:0]];
      push_op.is_raw = is_raw;
      push_op.last   = last;
      push_op.eos    = eos;

      buf_in  = buf_ff;
      held_in = held_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      eos_in  = eos_ff;
      copy_in = copy_ff;

      if (fin) begin
         busy_in = 1'b0;
         if (sp == cnt || eos) begin
            held_in = 2'd0;
         end else begin
            held_in = 2'(cnt - sp);
            for (int j = 0; j < 3; j++) buf_in[j] = arr[sp[1:0] + 2'(j)];
         end
      end else if (go) begin
         busy_in = 1'b1;
         buf_in  = arr;
         cnt_in  = cnt;
         pos_in  = nxt_pos;
         eos_in  = eos;
         copy_in = copy_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         pos_ff  <= 3'd0;
         eos_ff  <= 1'b0;
         copy_ff <= 2'd0;
      end else begin
         held_ff <= held_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
         eos_ff  <= eos_in;
         copy_ff <= copy_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

/* hdl/u8esc_queue.sv */
module u8esc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  u8esc_pkg::op_type         push_op,
   input  logic                      pop,
   output u8esc_pkg::op_type         head_op,
   output u8esc_pkg::q_status_type   q_status
);
   import u8esc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_op        = store_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_op;
   end

endmodule

/* hdl/u8esc_back.sv */
module u8esc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [u8esc_pkg::CAP_W-1:0]  csr_wr_data,
   input  u8esc_pkg::q_status_type      q_status,
   input  u8esc_pkg::op_type            head_op,
   output logic                         pop,
   u8esc_rsp_if.source                  rsp
);
   import u8esc_pkg::*;

   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
   localparam logic [BYTE_W-1:0] REPL_0    = 8'hEF;
   localparam logic [BYTE_W-1:0] REPL_1    = 8'hBF;
   localparam logic [BYTE_W-1:0] REPL_2    = 8'hBD;

   function automatic logic [BYTE_W-1:0] esc_letter(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] l;
      unique case (b)
         8'h07:   l = 8'h61;
         8'h08:   l = 8'h62;
         8'h09:   l = 8'h74;
         8'h0A:   l = 8'h6E;
         8'h0B:   l = 8'h76;
         8'h0C:   l = 8'h66;
         8'h0D:   l = 8'h72;
         default: l = 8'h00;
      endcase
      return l;
   endfunction

   function automatic logic is_hex_esc(input logic [BYTE_W-1:0] b);
      return (b <= 8'h1F) || (b == 8'h7F) || (b >= 8'h80 && b <= 8'h9F);
   endfunction

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] h);
      return (h < 4'd10) ? 8'h30 + {4'h0, h} : 8'h37 + {4'h0, h};
   endfunction

   function automatic logic [2:0] single_len(input logic [BYTE_W-1:0] b);
      logic [2:0] n;
      if (esc_letter(b) != 8'h00) n = 3'd2;
      else if (is_hex_esc(b)) n = 3'd4;
      else if (!b[7]) n = 3'd1;
      else n = 3'd3;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] single_byte(input logic [BYTE_W-1:0] b,
                                                     input logic [1:0] idx);
      logic [BYTE_W-1:0] o;
      if (esc_letter(b) != 8'h00) begin
         o = (idx == 2'd0) ? CH_BSLASH : esc_letter(b);
      end else if (is_hex_esc(b)) begin
         unique case (idx)
            2'd0: o = CH_BSLASH;
            2'd1: o = CH_X;
            2'd2: o = hex_digit(b[7:4]);
            2'd3: o = hex_digit(b[3:0]);
         endcase
      end else if (!b[7]) begin
         o = b;
      end else begin
         unique case (idx)
            2'd0:    o = REPL_0;
            2'd1:    o = REPL_1;
            default: o = REPL_2;
         endcase
      end
      return o;
   endfunction

   logic [1:0]        idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              run_last_ff, run_last_in;
   logic              done_ff, done_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;

   logic [2:0]        n_bytes;
   logic              final_byte, adv, fire, rl, dn;
   logic [LEN_W-1:0]  len_inc;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.run_last    = run_last_ff;
   assign rsp.string_done = done_ff;
   assign rsp.overflow    = ovf_ff;
   assign rsp.out_length  = olen_ff;

   always_comb begin
      n_bytes    = head_op.is_raw ? 3'd1 : single_len(head_op.data);
      final_byte = ({1'b0, idx_ff} + 3'd1) == n_bytes;
      adv        = !rsp_valid_ff || rsp.ready;
      fire       = !q_status.empty && adv;
      pop        = fire && final_byte;
      len_inc    = (len_ff == LEN_MAX) ? len_ff : len_ff + 1'b1;
      rl         = final_byte && head_op.last;
      dn         = rl && head_op.eos;

      idx_in       = idx_ff;
      len_in       = len_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      olen_in      = olen_ff;

      if (fire) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = head_op.is_raw ? head_op.data : single_byte(head_op.data, idx_ff);
         run_last_in  = rl;
         done_in      = dn;
         ovf_in       = dn && (({1'b0, len_inc} + 19'd1) > cap_ff);
         olen_in      = dn ? len_inc : '0;
         idx_in       = final_byte ? 2'd0 : idx_ff + 2'd1;
         len_in       = dn ? '0 : len_inc;
      end else if (adv) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         len_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
      ovf_ff      <= ovf_in;
      olen_ff     <= olen_in;
   end

endmodule

/* hdl/utf8_string_escaper.sv */
// the first output beat of an input beat passes through the op queue and then the output register
// throughput: one input beat per clock while each byte maps to one output byte and the queue is not full;
//   the front handles the bytes of a completed or rejected multibyte window one per clock
// an escape emits 2 to 4 output bytes; the QUEUE_DEPTH op queue lets the front run ahead
// reset: synchronous, clears held bytes, string length, queue and output valid;
//   capacity returns to 262144
module utf8_string_escaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   u8esc_req_if.sink                    req_bus,
   u8esc_rsp_if.source                  rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [u8esc_pkg::CAP_W-1:0]  csr_wr_data
);
   import u8esc_pkg::*;

   logic         q_push;
   logic         q_pop;
   op_type       q_push_op;
   op_type       q_head_op;
   q_status_type q_status;

   u8esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .q_status (q_status),
      .push     (q_push),
      .push_op  (q_push_op)
   );

   u8esc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_op  (q_push_op),
      .pop      (q_pop),
      .head_op  (q_head_op),
      .q_status (q_status)
   );

   u8esc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .head_op     (q_head_op),
      .pop         (q_pop),
      .rsp         (rsp_bus)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("op pushed into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("op popped from an empty queue");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.string_done |-> rsp_bus.run_last)
      else $error("string end beat not marked as last of its input beat");

   a_len_only_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.string_done |->
         (rsp_bus.out_length == '0) && !rsp_bus.overflow)
      else $error("length or overflow shown before string end");

endmodule
